@@ sv/absc_pkg.sv @@
// Shared types and constants for the A/B boot slot controller.
package absc_pkg;

	// Command codes carried by an input transaction.
	typedef enum logic [2:0] {
		CMD_SET_PENDING = 3'd0,
		CMD_CONFIRM     = 3'd1,
		CMD_MARK_BAD    = 3'd2,
		CMD_DECREMENT   = 3'd3,
		CMD_QUERY       = 3'd4
	} cmd_t;

	// Per-slot lifecycle states.
	typedef enum logic [2:0] {
		SLOT_EMPTY     = 3'd0,
		SLOT_VALID     = 3'd1,
		SLOT_PENDING   = 3'd2,
		SLOT_CONFIRMED = 3'd3,
		SLOT_BAD       = 3'd4
	} slot_state_t;

	// Slot pointer encodings.
	localparam logic [1:0] PTR_A    = 2'd0;
	localparam logic [1:0] PTR_B    = 2'd1;
	localparam logic [1:0] PTR_NONE = 2'd2;

	localparam logic [7:0] ATT_ONE = 8'd1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// Controller states: the result register is either empty or holds a result.
	typedef enum logic {
		CTRL_EMPTY = 1'b0,
		CTRL_FULL  = 1'b1
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
	} dp_cmd_t;

endpackage

@@ sv/absc_ctrl.sv @@
// Handshake controller: owns the result register occupancy and issues loads.
module absc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output absc_pkg::dp_cmd_t   dp_cmd
);

	absc_pkg::ctrl_state_t state_q;
	absc_pkg::ctrl_state_t state_d;
	logic                  load;

	// A new transaction may enter whenever the result register is free or is
	// being emptied in the same cycle.
	always_comb begin
		in_stall  = (state_q == absc_pkg::CTRL_FULL) && out_stall;
		out_valid = (state_q == absc_pkg::CTRL_FULL);
		load      = in_valid && !in_stall;
		dp_cmd.load = load;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			absc_pkg::CTRL_EMPTY: begin
				if (load) begin
					state_d = absc_pkg::CTRL_FULL;
				end
			end
			absc_pkg::CTRL_FULL: begin
				if (load) begin
					state_d = absc_pkg::CTRL_FULL;
				end else if (!out_stall) begin
					state_d = absc_pkg::CTRL_EMPTY;
				end
			end
			default: begin
				state_d = absc_pkg::CTRL_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= absc_pkg::CTRL_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/absc_datapath.sv @@
// Slot metadata registers, command evaluation and the result register.
module absc_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  absc_pkg::dp_cmd_t  dp_cmd,
	input  logic [2:0]         command,
	input  logic               slot,
	input  logic [31:0]        version,
	input  logic [31:0]        image_size,
	input  logic [31:0]        image_crc,
	input  logic [7:0]         attempts,
	output logic               status,
	output logic [7:0]         attempts_after,
	output logic [1:0]         active_now,
	output logic [1:0]         confirmed_now,
	output logic [1:0]         pending_now,
	output logic [2:0]         sel_state,
	output logic [7:0]         sel_attempts,
	output logic [31:0]        sel_version,
	output logic [31:0]        sel_size,
	output logic [31:0]        sel_crc
);

	absc_pkg::slot_state_t st_q [2];
	logic [7:0]            att_q [2];
	logic [31:0]           ver_q [2];
	logic [31:0]           size_q [2];
	logic [31:0]           crc_q [2];
	logic [1:0]            act_q;
	logic [1:0]            conf_q;
	logic [1:0]            pend_q;

	absc_pkg::slot_state_t st_d [2];
	logic [7:0]            att_d [2];
	logic [31:0]           ver_d [2];
	logic [31:0]           size_d [2];
	logic [31:0]           crc_d [2];
	logic [1:0]            act_d;
	logic [1:0]            conf_d;
	logic [1:0]            pend_d;
	logic                  err;
	logic [7:0]            after;

	logic                  status_q;
	logic [7:0]            after_q;
	logic [1:0]            act_out_q;
	logic [1:0]            conf_out_q;
	logic [1:0]            pend_out_q;
	logic [2:0]            sel_state_q;
	logic [7:0]            sel_att_q;
	logic [31:0]           sel_ver_q;
	logic [31:0]           sel_size_q;
	logic [31:0]           sel_crc_q;

	always_comb begin
		logic                  p;
		logic                  o;
		absc_pkg::slot_state_t os;
		st_d   = st_q;
		att_d  = att_q;
		ver_d  = ver_q;
		size_d = size_q;
		crc_d  = crc_q;
		act_d  = act_q;
		conf_d = conf_q;
		pend_d = pend_q;
		err    = 1'b0;
		after  = 8'd0;
		p      = pend_q[0];
		o      = ~slot;
		os     = st_q[o];
		case (absc_pkg::cmd_t'(command))
			absc_pkg::CMD_SET_PENDING: begin
				if (version == 32'd0 || image_size == 32'd0 || image_crc == 32'd0 ||
						attempts == 8'd0) begin
					err = 1'b1;
				end else begin
					ver_d[slot]  = version;
					size_d[slot] = image_size;
					crc_d[slot]  = image_crc;
					st_d[slot]   = absc_pkg::SLOT_PENDING;
					att_d[slot]  = attempts;
					pend_d       = {1'b0, slot};
				end
			end
			absc_pkg::CMD_CONFIRM: begin
				if (pend_q[1]) begin
					err = 1'b1;
				end else begin
					st_d[p]  = absc_pkg::SLOT_CONFIRMED;
					att_d[p] = 8'd0;
					act_d    = {1'b0, p};
					conf_d   = {1'b0, p};
					pend_d   = absc_pkg::PTR_NONE;
					if (st_q[~p] == absc_pkg::SLOT_CONFIRMED) begin
						st_d[~p] = absc_pkg::SLOT_VALID;
					end
				end
			end
			absc_pkg::CMD_MARK_BAD: begin
				st_d[slot]  = absc_pkg::SLOT_BAD;
				att_d[slot] = 8'd0;
				if (pend_q == {1'b0, slot}) begin
					pend_d = absc_pkg::PTR_NONE;
				end
				// The confirmed and active pointers at the failed slot fall back to the other slot if usable.
				if (conf_q == {1'b0, slot}) begin
					conf_d = (os == absc_pkg::SLOT_CONFIRMED || os == absc_pkg::SLOT_VALID)
						? {1'b0, o} : absc_pkg::PTR_NONE;
				end
				if (act_q == {1'b0, slot}) begin
					act_d = (os == absc_pkg::SLOT_CONFIRMED || os == absc_pkg::SLOT_VALID ||
						os == absc_pkg::SLOT_PENDING) ? {1'b0, o} : absc_pkg::PTR_NONE;
				end
			end
			absc_pkg::CMD_DECREMENT: begin
				if (pend_q[1] || st_q[p] != absc_pkg::SLOT_PENDING) begin
					err = 1'b1;
				end else begin
					if (att_q[p] != 8'd0) begin
						att_d[p] = att_q[p] - absc_pkg::ATT_ONE;
					end
					after = att_d[p];
				end
			end
			absc_pkg::CMD_QUERY: begin
				err = 1'b0;
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				st_q[i]   <= absc_pkg::SLOT_EMPTY;
				att_q[i]  <= 8'd0;
				ver_q[i]  <= 32'd0;
				size_q[i] <= 32'd0;
				crc_q[i]  <= 32'd0;
			end
			act_q  <= absc_pkg::PTR_NONE;
			conf_q <= absc_pkg::PTR_NONE;
			pend_q <= absc_pkg::PTR_NONE;
		end else if (dp_cmd.load) begin
			st_q   <= st_d;
			att_q  <= att_d;
			ver_q  <= ver_d;
			size_q <= size_d;
			crc_q  <= crc_d;
			act_q  <= act_d;
			conf_q <= conf_d;
			pend_q <= pend_d;
		end
	end

	// Result register: reports the state as it stands after the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= absc_pkg::STATUS_OK;
			after_q     <= 8'd0;
			act_out_q   <= absc_pkg::PTR_NONE;
			conf_out_q  <= absc_pkg::PTR_NONE;
			pend_out_q  <= absc_pkg::PTR_NONE;
			sel_state_q <= absc_pkg::SLOT_EMPTY;
			sel_att_q   <= 8'd0;
			sel_ver_q   <= 32'd0;
			sel_size_q  <= 32'd0;
			sel_crc_q   <= 32'd0;
		end else if (dp_cmd.load) begin
			status_q    <= err ? absc_pkg::STATUS_ERR : absc_pkg::STATUS_OK;
			after_q     <= after;
			act_out_q   <= act_d;
			conf_out_q  <= conf_d;
			pend_out_q  <= pend_d;
			sel_state_q <= st_d[slot];
			sel_att_q   <= att_d[slot];
			sel_ver_q   <= ver_d[slot];
			sel_size_q  <= size_d[slot];
			sel_crc_q   <= crc_d[slot];
		end
	end

	assign status         = status_q;
	assign attempts_after = after_q;
	assign active_now     = act_out_q;
	assign confirmed_now  = conf_out_q;
	assign pending_now    = pend_out_q;
	assign sel_state      = sel_state_q;
	assign sel_attempts   = sel_att_q;
	assign sel_version    = sel_ver_q;
	assign sel_size       = sel_size_q;
	assign sel_crc        = sel_crc_q;

endmodule

@@ sv/ab_boot_slot_controller_top.sv @@
// Top level of the A/B boot slot controller.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_stall  command, slot, version, image_size, image_crc, attempts
//   output    out_valid / out_stall status, attempts_after, active_now, confirmed_now,
//                                  pending_now, sel_state, sel_attempts, sel_version,
//                                  sel_size, sel_crc
//
// Each transaction is evaluated combinationally against the two slot records and its
// result appears in the result register on the following cycle. One transaction per
// cycle is sustained while out_stall is low; the single result register sets that rate.
// Reset empties both slots, sets all pointers to none and clears the result register.
// While a result is held by out_stall, in_stall is raised and input is held off.
module ab_boot_slot_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic        slot,
	input  logic [31:0] version,
	input  logic [31:0] image_size,
	input  logic [31:0] image_crc,
	input  logic [7:0]  attempts,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [7:0]  attempts_after,
	output logic [1:0]  active_now,
	output logic [1:0]  confirmed_now,
	output logic [1:0]  pending_now,
	output logic [2:0]  sel_state,
	output logic [7:0]  sel_attempts,
	output logic [31:0] sel_version,
	output logic [31:0] sel_size,
	output logic [31:0] sel_crc
);

	absc_pkg::dp_cmd_t dp_cmd;

	absc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd)
	);

	absc_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.command        (command),
		.slot           (slot),
		.version        (version),
		.image_size     (image_size),
		.image_crc      (image_crc),
		.attempts       (attempts),
		.status         (status),
		.attempts_after (attempts_after),
		.active_now     (active_now),
		.confirmed_now  (confirmed_now),
		.pending_now    (pending_now),
		.sel_state      (sel_state),
		.sel_attempts   (sel_attempts),
		.sel_version    (sel_version),
		.sel_size       (sel_size),
		.sel_crc        (sel_crc)
	);

	// An accepted transaction always yields a result on the next cycle.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted transaction produced no result");

	// Pointers only ever name slot A, slot B or none.
	a_ptr_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (active_now != 2'd3 && confirmed_now != 2'd3 && pending_now != 2'd3))
		else $error("slot pointer holds an illegal code");

	// A failed transaction reports no remaining attempts.
	a_err_no_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == absc_pkg::STATUS_ERR) |-> (attempts_after == 8'd0))
		else $error("error result carries attempts");

	// Nonzero attempts after a decrement imply a pending slot remains.
	a_after_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && attempts_after != 8'd0) |-> (pending_now != absc_pkg::PTR_NONE))
		else $error("attempts reported without a pending slot");

endmodule
